FILE: sv/ssi_pkg.sv
// Shared types and constants for the seek steering integrator.
// Holds the request, response and configuration types used by the top level
// and by the normalize-and-rescale pipeline. Depends on nothing.
package ssi_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIFF_WIDTH = 33;
   localparam int VEL_WIDTH  = 49;
   localparam int SQRT_STEPS = 32;
   localparam int QUOT_BITS  = 31;

   // Stages of one normalize-and-rescale unit: input, max, leading one, shift,
   // squares, root seed plus one per root step, length, decision, product
   // plus one per quotient bit, and the output register.
   localparam int NRM_LATENCY = 5 + (SQRT_STEPS + 1) + 2 + (QUOT_BITS + 1) + 1;

   localparam logic [30:0] TARGET_WEIGHT_RESET = 31'd65536;
   localparam logic [30:0] MIN_SPEED_RESET     = 31'd0;
   localparam logic [30:0] MAX_SPEED_RESET     = 31'd39321600;
   localparam logic [30:0] MAX_STEER_RESET     = 31'd6553600;

   typedef enum logic [1:0] {
      CSR_TARGET_WEIGHT = 2'd0,
      CSR_MIN_SPEED     = 2'd1,
      CSR_MAX_SPEED     = 2'd2,
      CSR_MAX_STEER     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [31:0] goal_z;
      logic               chasing;
      logic        [15:0] step_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               facing_valid;
   } rsp_type;

   // Bounds applied by a normalize-and-rescale unit: rescale when the length
   // exceeds thresh, to a speed clamped into lo and hi.
   typedef struct packed {
      logic [30:0] thresh;
      logic [30:0] lo;
      logic [30:0] hi;
   } lim_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic      [15:0] dt;
      logic             chase;
   } agent_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic      [15:0] dt;
   } move_type;

endpackage

FILE: sv/ssi_nrm.sv
// Pipelined normalize-and-rescale unit for a three-component vector.
// Finds the length by a 32-step square root and rescales with a 31-step
// divider, carrying a side word along. Depends on ssi_pkg.
module ssi_nrm
   import ssi_pkg::*;
#(
   parameter int VecWidth  = 33,
   parameter int SideWidth = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0][VecWidth-1:0]         in_vec,
   input  logic [SideWidth-1:0]             in_side,
   input  lim_type                          lim,
   output logic                             out_valid,
   output logic [2:0][VecWidth-1:0]         out_vec,
   output logic [SideWidth-1:0]             out_side
);

   localparam int RshMax   = VecWidth - 31;
   localparam int RshWidth = $clog2(RshMax + 1);
   localparam int PosWidth = $clog2(VecWidth);
   localparam int LenWidth = 32 + RshMax;
   localparam int ProdWidth = 2 * QUOT_BITS;

   typedef logic [2:0][VecWidth-1:0] vec_type;
   typedef logic [2:0][30:0] m31_type;

   typedef struct packed {
      vec_type              vec;
      logic [SideWidth-1:0] side;
   } carry_type;

   typedef struct packed {
      carry_type             c;
      logic [2:0]            neg;
      logic                  zero;
      m31_type               m;
      logic [4:0]            lsh;
      logic [RshWidth-1:0]   rsh;
      logic [63:0]           x;
      logic [63:0]           r;
   } root_type;

   typedef struct packed {
      carry_type             c;
      logic [2:0]            neg;
      logic                  zero;
      m31_type               m;
      logic [31:0]           norm;
      logic [LenWidth-1:0]   len;
   } len_type;

   typedef struct packed {
      carry_type             c;
      logic [2:0]            neg;
      logic                  apply;
      m31_type               m;
      logic [31:0]           norm;
      logic [30:0]           sp;
   } dec_type;

   typedef struct packed {
      carry_type                  c;
      logic [2:0]                 neg;
      logic                       apply;
      logic [31:0]                norm;
      logic [2:0][ProdWidth-1:0]  prod;
      logic [2:0][31:0]           rem;
      logic [2:0][QUOT_BITS-1:0]  quo;
   } div_type;

   logic [NRM_LATENCY-1:0] vld_ff, vld_in;

   carry_type c0_ff, c0_in, c1_ff, c2_ff, c3_ff;
   vec_type   mag0_ff, mag0_in, mag1_ff, mag2_ff;
   logic [2:0] neg0_ff, neg0_in, neg1_ff, neg2_ff, neg3_ff;
   logic [VecWidth-1:0] mx1_ff, mx1_in;
   logic [PosWidth-1:0] pos2_ff, pos2_in;
   logic zero2_ff, zero2_in, zero3_ff;
   m31_type m3_ff, m3_in;
   logic [4:0] lsh3_ff, lsh3_in;
   logic [RshWidth-1:0] rsh3_ff, rsh3_in;
   carry_type c4_ff;
   logic [2:0] neg4_ff;
   logic zero4_ff;
   m31_type m4_ff;
   logic [4:0] lsh4_ff;
   logic [RshWidth-1:0] rsh4_ff;
   logic [2:0][61:0] sq4_ff, sq4_in;

   root_type root_ff [SQRT_STEPS+1];
   root_type root_in [SQRT_STEPS+1];
   len_type  len_ff, len_in;
   dec_type  dec_ff, dec_in;
   div_type  div_ff [QUOT_BITS+1];
   div_type  div_in [QUOT_BITS+1];
   vec_type  out_vec_ff, out_vec_in;
   logic [SideWidth-1:0] out_side_ff;

   assign vld_in = {vld_ff[NRM_LATENCY-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Magnitudes and signs.
   always_comb begin
      c0_in.vec  = in_vec;
      c0_in.side = in_side;
      for (int k = 0; k < 3; k++) begin
         neg0_in[k] = in_vec[k][VecWidth-1];
         mag0_in[k] = neg0_in[k] ? (VecWidth'(0) - in_vec[k]) : in_vec[k];
      end
   end

   always_comb begin
      mx1_in = (mag0_ff[0] > mag0_ff[1]) ? mag0_ff[0] : mag0_ff[1];
      if (mag0_ff[2] > mx1_in) begin
         mx1_in = mag0_ff[2];
      end
   end

   always_comb begin
      pos2_in  = '0;
      zero2_in = (mx1_ff == '0);
      for (int b = 0; b < VecWidth; b++) begin
         if (mx1_ff[b]) begin
            pos2_in = PosWidth'(b);
         end
      end
   end

   // Bring the largest magnitude into the range from 2^30 up to 2^31.
   always_comb begin
      lsh3_in = '0;
      rsh3_in = '0;
      if (pos2_ff >= PosWidth'(30)) begin
         rsh3_in = RshWidth'(pos2_ff - PosWidth'(30));
         for (int k = 0; k < 3; k++) begin
            m3_in[k] = 31'(mag2_ff[k] >> rsh3_in);
         end
      end else begin
         lsh3_in = 5'(PosWidth'(30) - pos2_ff);
         for (int k = 0; k < 3; k++) begin
            m3_in[k] = 31'(mag2_ff[k] << lsh3_in);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq4_in[k] = m3_ff[k] * m3_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      c0_ff    <= c0_in;
      mag0_ff  <= mag0_in;
      neg0_ff  <= neg0_in;
      c1_ff    <= c0_ff;
      mag1_ff  <= mag0_ff;
      neg1_ff  <= neg0_ff;
      mx1_ff   <= mx1_in;
      c2_ff    <= c1_ff;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      pos2_ff  <= pos2_in;
      zero2_ff <= zero2_in;
      c3_ff    <= c2_ff;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
      m3_ff    <= m3_in;
      lsh3_ff  <= lsh3_in;
      rsh3_ff  <= rsh3_in;
      c4_ff    <= c3_ff;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
      m4_ff    <= m3_ff;
      lsh4_ff  <= lsh3_ff;
      rsh4_ff  <= rsh3_ff;
      sq4_ff   <= sq4_in;
   end

   always_comb begin
      root_in[0].c    = c4_ff;
      root_in[0].neg  = neg4_ff;
      root_in[0].zero = zero4_ff;
      root_in[0].m    = m4_ff;
      root_in[0].lsh  = lsh4_ff;
      root_in[0].rsh  = rsh4_ff;
      root_in[0].x    = 64'(sq4_ff[0]) + 64'(sq4_ff[1]) + 64'(sq4_ff[2]);
      root_in[0].r    = '0;
   end

   // Floor square root, one result bit per stage.
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_root
      localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * i);
      logic [63:0] trial;
      always_comb begin
         root_in[i+1] = root_ff[i];
         trial = root_ff[i].r + StepBit;
         if (root_ff[i].x >= trial) begin
            root_in[i+1].x = root_ff[i].x - trial;
            root_in[i+1].r = (root_ff[i].r >> 1) + StepBit;
         end else begin
            root_in[i+1].r = root_ff[i].r >> 1;
         end
      end
   end

   // Length of the original vector: undo the scaling on the root.
   always_comb begin
      len_in.c    = root_ff[SQRT_STEPS].c;
      len_in.neg  = root_ff[SQRT_STEPS].neg;
      len_in.zero = root_ff[SQRT_STEPS].zero;
      len_in.m    = root_ff[SQRT_STEPS].m;
      len_in.norm = root_ff[SQRT_STEPS].r[31:0];
      if (root_ff[SQRT_STEPS].lsh != '0) begin
         len_in.len = LenWidth'(len_in.norm) >> root_ff[SQRT_STEPS].lsh;
      end else begin
         len_in.len = LenWidth'(len_in.norm) << root_ff[SQRT_STEPS].rsh;
      end
   end

   // Target length; a lower bound above the upper bound wins for short vectors.
   always_comb begin
      dec_in.c     = len_ff.c;
      dec_in.neg   = len_ff.neg;
      dec_in.m     = len_ff.m;
      dec_in.norm  = len_ff.norm;
      dec_in.apply = !len_ff.zero && (len_ff.len > LenWidth'(lim.thresh));
      priority if (len_ff.len < LenWidth'(lim.lo)) begin
         dec_in.sp = lim.lo;
      end else if (len_ff.len >= LenWidth'(lim.hi)) begin
         dec_in.sp = lim.hi;
      end else begin
         dec_in.sp = len_ff.len[30:0];
      end
   end

   always_comb begin
      div_in[0].c     = dec_ff.c;
      div_in[0].neg   = dec_ff.neg;
      div_in[0].apply = dec_ff.apply;
      div_in[0].norm  = dec_ff.norm;
      div_in[0].rem   = '0;
      div_in[0].quo   = '0;
      for (int k = 0; k < 3; k++) begin
         div_in[0].prod[k] = dec_ff.m[k] * dec_ff.sp;
      end
   end

   // Restoring division of the product by the norm. The quotient never
   // exceeds the target length, so it fits in 31 bits.
   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
      localparam int QBit = QUOT_BITS - 1 - j;
      logic [2:0][31:0] rem_prev;
      logic [2:0][32:0] trial;
      always_comb begin
         div_in[j+1] = div_ff[j];
         for (int k = 0; k < 3; k++) begin
            if (j == 0) begin
               rem_prev[k] = {1'b0, div_ff[j].prod[k][ProdWidth-1:QUOT_BITS]};
            end else begin
               rem_prev[k] = div_ff[j].rem[k];
            end
            trial[k] = {rem_prev[k], div_ff[j].prod[k][QBit]};
            if (trial[k] >= {1'b0, div_ff[j].norm}) begin
               div_in[j+1].rem[k]       = 32'(trial[k] - {1'b0, div_ff[j].norm});
               div_in[j+1].quo[k][QBit] = 1'b1;
            end else begin
               div_in[j+1].rem[k] = trial[k][31:0];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (div_ff[QUOT_BITS].apply) begin
            out_vec_in[k] = div_ff[QUOT_BITS].neg[k]
               ? (VecWidth'(0) - VecWidth'(div_ff[QUOT_BITS].quo[k]))
               : VecWidth'(div_ff[QUOT_BITS].quo[k]);
         end else begin
            out_vec_in[k] = div_ff[QUOT_BITS].c.vec[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= SQRT_STEPS; i++) begin
         root_ff[i] <= root_in[i];
      end
      len_ff <= len_in;
      dec_ff <= dec_in;
      for (int j = 0; j <= QUOT_BITS; j++) begin
         div_ff[j] <= div_in[j];
      end
      out_vec_ff  <= out_vec_in;
      out_side_ff <= div_ff[QUOT_BITS].c.side;
   end

   assign out_valid = vld_ff[NRM_LATENCY-1];
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: sv/seek_steering_integrator_top.sv
// Throughput: one agent per cycle, every cycle; busy is high only until the
// first clock after reset, and the result strobe cannot be held off.
// The pipeline is three normalize-and-rescale units of 73 stages each, with
// a 32-step square root and a 31-step divider, plus nine single stages for the
// input, the steering difference, the products and the output.
// Reset drops all beats in flight and loads the register defaults.
module seek_steering_integrator_top
   import ssi_pkg::*;
#(
   parameter int NEAR_ZERO = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int TotalLatency = 1 + 3 * NRM_LATENCY + 1 + 4 + 3;

   // Configuration registers.
   logic [30:0] weight_ff, weight_in, min_speed_ff, min_speed_in;
   logic [30:0] max_speed_ff, max_speed_in, max_steer_ff, max_steer_in;
   logic        busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_comb begin
      weight_in    = weight_ff;
      min_speed_in = min_speed_ff;
      max_speed_in = max_speed_ff;
      max_steer_in = max_steer_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_WEIGHT: weight_in    = csr_data[30:0];
            CSR_MIN_SPEED:     min_speed_in = csr_data[30:0];
            CSR_MAX_SPEED:     max_speed_in = csr_data[30:0];
            CSR_MAX_STEER:     max_steer_in = csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= TARGET_WEIGHT_RESET;
         min_speed_ff <= MIN_SPEED_RESET;
         max_speed_ff <= MAX_SPEED_RESET;
         max_steer_ff <= MAX_STEER_RESET;
         busy_ff      <= 1'b1;
      end else begin
         weight_ff    <= weight_in;
         min_speed_ff <= min_speed_in;
         max_speed_ff <= max_speed_in;
         max_steer_ff <= max_steer_in;
         busy_ff      <= 1'b0;
      end
   end

   // Input register.
   logic      in_vld_ff;
   req_type   in_ff;
   agent_type agent_in;
   logic [2:0][DIFF_WIDTH-1:0] diff_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_ff <= req_payload;
   end

   always_comb begin
      agent_in.pos   = {in_ff.pos_x, in_ff.pos_y, in_ff.pos_z};
      agent_in.vel   = {in_ff.vel_x, in_ff.vel_y, in_ff.vel_z};
      agent_in.dt    = in_ff.step_time;
      agent_in.chase = in_ff.chasing;
      diff_in[2] = {in_ff.goal_x[31], in_ff.goal_x} - {in_ff.pos_x[31], in_ff.pos_x};
      diff_in[1] = {in_ff.goal_y[31], in_ff.goal_y} - {in_ff.pos_y[31], in_ff.pos_y};
      diff_in[0] = {in_ff.goal_z[31], in_ff.goal_z} - {in_ff.pos_z[31], in_ff.pos_z};
   end

   // Desired velocity: the offset to the goal, scaled to the top speed.
   lim_type lim_seek, lim_steer, lim_speed;
   logic    seek_vld;
   logic [2:0][DIFF_WIDTH-1:0] seek_vec;
   agent_type seek_side;

   assign lim_seek  = '{thresh: '0, lo: max_speed_ff, hi: max_speed_ff};
   assign lim_steer = '{thresh: max_steer_ff, lo: max_steer_ff, hi: max_steer_ff};
   assign lim_speed = '{thresh: 31'(NEAR_ZERO), lo: min_speed_ff, hi: max_speed_ff};

   ssi_nrm #(
      .VecWidth  (DIFF_WIDTH),
      .SideWidth ($bits(agent_type))
   ) u_seek (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .in_vec    (diff_in),
      .in_side   (agent_in),
      .lim       (lim_seek),
      .out_valid (seek_vld),
      .out_vec   (seek_vec),
      .out_side  (seek_side)
   );

   // Raw steering: desired minus current velocity.
   logic      st_vld_ff;
   agent_type st_agent_ff;
   logic [2:0][DIFF_WIDTH-1:0] st_ff, st_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         st_in[k] = seek_vec[k] - {seek_side.vel[k][31], seek_side.vel[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
      end else begin
         st_vld_ff <= seek_vld;
      end
      st_ff       <= st_in;
      st_agent_ff <= seek_side;
   end

   // Steering limited to its largest magnitude.
   logic      steer_vld;
   logic [2:0][DIFF_WIDTH-1:0] steer_vec;
   agent_type steer_side;

   ssi_nrm #(
      .VecWidth  (DIFF_WIDTH),
      .SideWidth ($bits(agent_type))
   ) u_steer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_vld_ff),
      .in_vec    (st_ff),
      .in_side   (st_agent_ff),
      .lim       (lim_steer),
      .out_valid (steer_vld),
      .out_vec   (steer_vec),
      .out_side  (steer_side)
   );

   // Weighting and integration. The steering magnitude stays below 2^32 and
   // the weighted acceleration below 2^47, so neither product cap is reached.
   logic [3:0]       acc_vld_ff;
   agent_type        m0_agent_ff, m1_agent_ff, m2_agent_ff;
   move_type         m3_move_ff;
   logic [2:0]       m0_neg_ff, m1_neg_ff, m2_neg_ff;
   logic [2:0][31:0] m0_mag_ff, m0_mag_in;
   logic [2:0][62:0] m1_prod_ff, m1_prod_in, m2_prod_ff, m2_prod_in;
   logic [2:0][VEL_WIDTH-1:0] m3_vel_ff, m3_vel_in;
   logic [2:0][VEL_WIDTH-1:0] dv;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         m0_mag_in[k]  = 32'(steer_vec[k][DIFF_WIDTH-1]
            ? (DIFF_WIDTH'(0) - steer_vec[k]) : steer_vec[k]);
         m1_prod_in[k] = m0_mag_ff[k] * weight_ff;
         m2_prod_in[k] = m1_prod_ff[k][62:FRAC_BITS] * m2_agent_dt();
         dv[k] = VEL_WIDTH'(m2_prod_ff[k][62:FRAC_BITS]);
         if (!m2_agent_ff.chase) begin
            dv[k] = '0;
         end else if (m2_neg_ff[k]) begin
            dv[k] = VEL_WIDTH'(0) - dv[k];
         end
         m3_vel_in[k] = {{(VEL_WIDTH-32){m2_agent_ff.vel[k][31]}}, m2_agent_ff.vel[k]} + dv[k];
      end
   end

   function automatic logic [15:0] m2_agent_dt();
      return m1_agent_ff.dt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else begin
         acc_vld_ff <= {acc_vld_ff[2:0], steer_vld};
      end
      m0_agent_ff <= steer_side;
      m0_mag_ff   <= m0_mag_in;
      for (int k = 0; k < 3; k++) begin
         m0_neg_ff[k] <= steer_vec[k][DIFF_WIDTH-1];
      end
      m1_agent_ff    <= m0_agent_ff;
      m1_neg_ff      <= m0_neg_ff;
      m1_prod_ff     <= m1_prod_in;
      m2_agent_ff    <= m1_agent_ff;
      m2_neg_ff      <= m1_neg_ff;
      m2_prod_ff     <= m2_prod_in;
      m3_move_ff.pos <= m2_agent_ff.pos;
      m3_move_ff.dt  <= m2_agent_ff.dt;
      m3_vel_ff      <= m3_vel_in;
   end

   // Speed clamp.
   logic     spd_vld;
   logic [2:0][VEL_WIDTH-1:0] spd_vec;
   move_type spd_side;

   ssi_nrm #(
      .VecWidth  (VEL_WIDTH),
      .SideWidth ($bits(move_type))
   ) u_speed (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_vld_ff[3]),
      .in_vec    (m3_vel_ff),
      .in_side   (m3_move_ff),
      .lim       (lim_speed),
      .out_valid (spd_vld),
      .out_vec   (spd_vec),
      .out_side  (spd_side)
   );

   // Saturation, position advance and the facing flag.
   logic [2:0]       fin_vld_ff;
   move_type         f0_move_ff, f1_move_ff;
   logic [2:0][31:0] f0_vel_ff, f0_vel_in, f0_mag_ff, f0_mag_in, f1_vel_ff;
   logic [2:0]       f1_neg_ff;
   logic             f0_facing_ff, f0_facing_in, f1_facing_ff;
   logic [2:0][47:0] f1_prod_ff, f1_prod_in;
   logic [2:0][32:0] pos_sum;
   logic [2:0][31:0] pos_sat;
   logic [2:0][32:0] step_v;

   always_comb begin
      f0_facing_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         priority if (!spd_vec[k][VEL_WIDTH-1] && (|spd_vec[k][VEL_WIDTH-2:31])) begin
            f0_vel_in[k] = 32'h7FFF_FFFF;
         end else if (spd_vec[k][VEL_WIDTH-1] && !(&spd_vec[k][VEL_WIDTH-2:31])) begin
            f0_vel_in[k] = 32'h8000_0000;
         end else begin
            f0_vel_in[k] = spd_vec[k][31:0];
         end
         f0_mag_in[k] = f0_vel_in[k][31] ? (32'd0 - f0_vel_in[k]) : f0_vel_in[k];
         if (f0_mag_in[k] > 32'(NEAR_ZERO)) begin
            f0_facing_in = 1'b1;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         f1_prod_in[k] = f0_mag_ff[k] * f0_move_ff.dt;
         step_v[k] = {1'b0, f1_prod_ff[k][47:FRAC_BITS]};
         if (f1_neg_ff[k]) begin
            step_v[k] = 33'd0 - step_v[k];
         end
         pos_sum[k] = {f1_move_ff.pos[k][31], f1_move_ff.pos[k]} + step_v[k];
         if (pos_sum[k][32] != pos_sum[k][31]) begin
            pos_sat[k] = pos_sum[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            pos_sat[k] = pos_sum[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= '0;
      end else begin
         fin_vld_ff <= {fin_vld_ff[1:0], spd_vld};
      end
      f0_move_ff   <= spd_side;
      f0_vel_ff    <= f0_vel_in;
      f0_mag_ff    <= f0_mag_in;
      f0_facing_ff <= f0_facing_in;
      f1_move_ff   <= f0_move_ff;
      f1_vel_ff    <= f0_vel_ff;
      f1_prod_ff   <= f1_prod_in;
      f1_facing_ff <= f0_facing_ff;
      for (int k = 0; k < 3; k++) begin
         f1_neg_ff[k] <= f0_vel_ff[k][31];
      end
      rsp_payload.new_pos_x    <= pos_sat[2];
      rsp_payload.new_pos_y    <= pos_sat[1];
      rsp_payload.new_pos_z    <= pos_sat[0];
      rsp_payload.new_vel_x    <= f1_vel_ff[2];
      rsp_payload.new_vel_y    <= f1_vel_ff[1];
      rsp_payload.new_vel_z    <= f1_vel_ff[0];
      rsp_payload.facing_valid <= f1_facing_ff;
   end

   assign rsp_strobe = fin_vld_ff[2];

   // Every accepted beat comes out after the fixed pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TotalLatency rsp_strobe)
      else $error("accepted beat did not produce a result in time");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_vld_ff, TotalLatency - 1))
      else $error("result strobe without an accepted beat");

   // A zero frame time never moves the agent; the check looks at the x position.
   a_still: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && in_ff.step_time == 16'd0) |-> ##(TotalLatency - 1)
      (rsp_payload.new_pos_x == $past(in_ff.pos_x, TotalLatency - 1)))
      else $error("position changed with zero frame time");

endmodule
